>>> rtl/fpba_pkg.sv
package fpba_pkg;

    localparam int NUM_BLOCKS_DEF = 64;
    localparam int SIZE_BITS_DEF  = 16;

    localparam int OPCODE_W   = 1;
    localparam int SLOT_W     = 6;
    localparam int VALUE_W    = 16;
    localparam int MODE_W     = 2;
    localparam int COUNT_W    = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    localparam logic [OPCODE_W-1:0] OP_LOAD  = 1'b0;
    localparam logic [OPCODE_W-1:0] OP_ALLOC = 1'b1;

    localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 1'b1;

    typedef struct packed {
        logic fits;
        logic lt_best;
        logic gt_best;
    } alu_flags_t;

endpackage

>>> rtl/fpba_ram.sv
module fpba_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                   aclk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/fpba_alu.sv
module fpba_alu #(
    parameter int SIZE_BITS = fpba_pkg::SIZE_BITS_DEF
) (
    input  logic [SIZE_BITS-1:0] operand,
    input  logic [SIZE_BITS-1:0] request,
    input  logic [SIZE_BITS-1:0] best,
    output logic [SIZE_BITS-1:0] diff,
    output fpba_pkg::alu_flags_t flags
);

    logic [SIZE_BITS:0] sub_full;

    assign sub_full      = {1'b0, operand} - {1'b0, request};
    assign diff          = sub_full[SIZE_BITS-1:0];
    assign flags.fits    = ~sub_full[SIZE_BITS];
    assign flags.lt_best = operand < best;
    assign flags.gt_best = operand > best;

endmodule

>>> rtl/fit_policy_block_allocator.sv
// Channel  | Ports                                        | Direction
// ---------+----------------------------------------------+----------
// input    | s_valid s_ready s_opcode s_block_slot         | in
//          | s_size_value                                 |
// result   | m_valid m_ready m_granted m_chosen_block      | out
//          | m_space_left                                 |
// config   | cfg_wr_en cfg_index cfg_wdata                | in
//
// Load transaction: table written on accept. Allocate transaction: result valid and input
// ready again together after a scan of N = min(block_count, NUM_BLOCKS) entries, fewer
// under first fit, through the single table read port feeding one shared subtract/compare
// unit, one entry per cycle, then a read drain step, then a write-back step.
// Reset clears control only; table entries are undefined until loaded, no clearing pass.
// Write-back waits while the previous result is still held on the result channel.
module fit_policy_block_allocator #(
    parameter int NUM_BLOCKS = fpba_pkg::NUM_BLOCKS_DEF,
    parameter int SIZE_BITS  = fpba_pkg::SIZE_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [fpba_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fpba_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [fpba_pkg::OPCODE_W-1:0]       s_opcode,
    input  logic [fpba_pkg::SLOT_W-1:0]         s_block_slot,
    input  logic [fpba_pkg::VALUE_W-1:0]        s_size_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_granted,
    output logic [fpba_pkg::SLOT_W-1:0]         m_chosen_block,
    output logic [fpba_pkg::VALUE_W-1:0]        m_space_left
);

    localparam int AW  = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CNW = $clog2(NUM_BLOCKS + 1);
    localparam int CW  = (CNW > fpba_pkg::COUNT_W) ? CNW : fpba_pkg::COUNT_W;
    localparam int SW  = (SIZE_BITS > fpba_pkg::VALUE_W) ? SIZE_BITS : fpba_pkg::VALUE_W;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_WRITE = 2'd2;

    logic [1:0]                      state_reg, state_next;
    logic [fpba_pkg::MODE_W-1:0]     fit_mode_reg;
    logic [fpba_pkg::COUNT_W-1:0]    block_count_reg;
    logic [fpba_pkg::MODE_W-1:0]     mode_reg, mode_next;
    logic [CW-1:0]                   limit_reg, limit_next;
    logic [CW-1:0]                   addr_reg, addr_next;
    logic                            rd_vld_reg, rd_vld_next;
    logic [CW-1:0]                   rd_idx_reg, rd_idx_next;
    logic                            found_reg, found_next;
    logic [CW-1:0]                   pick_reg, pick_next;
    logic [SIZE_BITS-1:0]            best_reg, best_next;
    logic [SIZE_BITS-1:0]            req_reg, req_next;
    logic                            m_valid_reg, m_valid_next;
    logic                            granted_reg, granted_next;
    logic [fpba_pkg::SLOT_W-1:0]     chosen_reg, chosen_next;
    logic [fpba_pkg::VALUE_W-1:0]    space_reg, space_next;

    logic                            ram_we;
    logic [AW-1:0]                   ram_waddr;
    logic [SIZE_BITS-1:0]            ram_wdata;
    logic                            ram_re;
    logic [SIZE_BITS-1:0]            ram_rdata;

    logic [SIZE_BITS-1:0]            alu_a;
    logic [SIZE_BITS-1:0]            alu_diff;
    fpba_pkg::alu_flags_t            alu_flags;

    logic [CW-1:0]                   limit_w;
    logic                            first_mode;
    logic                            stop;
    logic                            better;
    logic [SW-1:0]                   diff_ext;

    fpba_ram #(
        .WIDTH (SIZE_BITS),
        .DEPTH (NUM_BLOCKS)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (addr_reg[AW-1:0]),
        .rd_data (ram_rdata)
    );

    fpba_alu #(
        .SIZE_BITS (SIZE_BITS)
    ) u_alu (
        .operand (alu_a),
        .request (req_reg),
        .best    (best_reg),
        .diff    (alu_diff),
        .flags   (alu_flags)
    );

    assign limit_w = (CW'(block_count_reg) > CW'(NUM_BLOCKS)) ? CW'(NUM_BLOCKS)
                                                            : CW'(block_count_reg);
    assign first_mode = (mode_reg != fpba_pkg::MODE_BEST) &&
                        (mode_reg != fpba_pkg::MODE_WORST);
    assign stop       = found_reg && first_mode;
    assign alu_a      = (state_reg == ST_WRITE) ? best_reg : ram_rdata;
    assign better     = ((mode_reg == fpba_pkg::MODE_BEST) && alu_flags.lt_best) ||
                        ((mode_reg == fpba_pkg::MODE_WORST) && alu_flags.gt_best);
    assign diff_ext   = SW'(alu_diff);
    assign ram_re     = (state_reg == ST_SCAN) && (addr_reg < limit_reg) && !stop;

    always_comb begin
        state_next   = state_reg;
        mode_next    = mode_reg;
        limit_next   = limit_reg;
        addr_next    = addr_reg;
        rd_vld_next  = 1'b0;
        rd_idx_next  = rd_idx_reg;
        found_next   = found_reg;
        pick_next    = pick_reg;
        best_next    = best_reg;
        req_next     = req_reg;
        m_valid_next = m_valid_reg && !m_ready;
        granted_next = granted_reg;
        chosen_next  = chosen_reg;
        space_next   = space_reg;
        ram_we       = 1'b0;
        ram_waddr    = AW'(s_block_slot);
        ram_wdata    = SIZE_BITS'(s_size_value);
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_opcode == fpba_pkg::OP_LOAD) begin
                        ram_we = int'(s_block_slot) < NUM_BLOCKS;
                    end else begin
                        req_next   = SIZE_BITS'(s_size_value);
                        mode_next  = fit_mode_reg;
                        limit_next = limit_w;
                        addr_next  = '0;
                        found_next = 1'b0;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (ram_re) begin
                    rd_vld_next = 1'b1;
                    rd_idx_next = addr_reg;
                    addr_next   = addr_reg + 1'b1;
                end
                if (rd_vld_reg && !stop && alu_flags.fits && (!found_reg || better)) begin
                    found_next = 1'b1;
                    pick_next  = rd_idx_reg;
                    best_next  = ram_rdata;
                end
                if (!ram_re && !rd_vld_reg) begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                if (!m_valid_reg || m_ready) begin
                    ram_we       = found_reg;
                    ram_waddr    = pick_reg[AW-1:0];
                    ram_wdata    = alu_diff;
                    m_valid_next = 1'b1;
                    granted_next = found_reg;
                    chosen_next  = found_reg ? pick_reg[fpba_pkg::SLOT_W-1:0] : '0;
                    space_next   = found_reg ? diff_ext[fpba_pkg::VALUE_W-1:0] : '0;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            fit_mode_reg    <= fpba_pkg::MODE_FIRST;
            block_count_reg <= '0;
            rd_vld_reg      <= 1'b0;
            found_reg       <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rd_vld_reg  <= rd_vld_next;
            found_reg   <= found_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    fpba_pkg::CFG_FIT_MODE: begin
                        fit_mode_reg <= cfg_wdata[fpba_pkg::MODE_W-1:0];
                    end
                    fpba_pkg::CFG_BLOCK_COUNT: begin
                        block_count_reg <= cfg_wdata[fpba_pkg::COUNT_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg    <= mode_next;
        limit_reg   <= limit_next;
        addr_reg    <= addr_next;
        rd_idx_reg  <= rd_idx_next;
        pick_reg    <= pick_next;
        best_reg    <= best_next;
        req_reg     <= req_next;
        granted_reg <= granted_next;
        chosen_reg  <= chosen_next;
        space_reg   <= space_next;
    end

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_granted      = granted_reg;
    assign m_chosen_block = chosen_reg;
    assign m_space_left   = space_reg;

`ifndef SYNTH
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (state_reg == ST_IDLE))
        else $error("input ready outside idle");

    a_read_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN && rd_vld_reg) |-> (rd_idx_reg < limit_reg))
        else $error("table read beyond block count");

    a_pick_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WRITE && found_reg) |-> (pick_reg < limit_reg))
        else $error("chosen block beyond block count");

    a_writeback_found: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WRITE && ram_we) |-> found_reg)
        else $error("write-back without a fitting block");

    a_denied_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_granted) |-> (m_chosen_block == '0 && m_space_left == '0))
        else $error("denied result with nonzero fields");
`endif

endmodule
